### sv/sqd_pkg.sv
// Shared types, widths and helper functions for the squared-distance top-K scan.
package sqd_pkg;

    localparam int NDIM     = 14;
    localparam int DIM_W    = 16;
    localparam int DIFF_W   = DIM_W + 1;
    localparam int SQ_W     = 2 * DIM_W;
    localparam int GRP_SIZE = 4;
    localparam int NGRP     = (NDIM + GRP_SIZE - 1) / GRP_SIZE;
    localparam int GRP_W    = SQ_W + 2;
    localparam int DIST_W   = 36;
    localparam int LABEL_W  = 8;
    localparam int ID_W     = 32;

    localparam int IN_W     = NDIM * DIM_W + LABEL_W + ID_W;
    localparam int SLOT_W   = DIST_W + LABEL_W + ID_W;
    localparam int OUT_W    = ((SLOT_W + 7) / 8) * 8;
    localparam int PAD_W    = OUT_W - SLOT_W;

    localparam int ADDR_W   = 5;
    localparam int CFG_W    = 64;
    localparam int Q3_W     = 32;
    localparam int QRY_W    = 3 * CFG_W + Q3_W;

    localparam logic [1:0] REG_Q0 = 2'd0;
    localparam logic [1:0] REG_Q1 = 2'd1;
    localparam logic [1:0] REG_Q2 = 2'd2;
    localparam logic [1:0] REG_Q3 = 2'd3;

    typedef logic signed [DIM_W-1:0] dim_t;

    typedef struct packed {
        logic               last;
        logic [LABEL_W-1:0] label;
        logic [ID_W-1:0]    id;
    } meta_t;

    typedef struct packed {
        logic [DIST_W-1:0]  distance;
        logic [LABEL_W-1:0] label;
        logic [ID_W-1:0]    id;
    } slot_t;

    localparam slot_t SLOT_EMPTY = '{distance: '1, label: '0, id: '1};

    // Smaller distance wins; on equal distance the lower id wins.
    function automatic logic pair_better(slot_t a, slot_t b);
        return (a.distance < b.distance) ||
               ((a.distance == b.distance) && (a.id < b.id));
    endfunction

endpackage

### sv/sqd_lane.sv
// One distance lane: difference of one dimension, magnitude and its square, registered.
module sqd_lane
(
    input  logic                     clk,
    input  logic                     en,
    input  sqd_pkg::dim_t            rec,
    input  sqd_pkg::dim_t            qry,
    output logic [sqd_pkg::SQ_W-1:0] sq_reg
);
    import sqd_pkg::*;

    logic signed [DIFF_W-1:0] diff;
    logic [DIFF_W-1:0]        mag;
    logic [SQ_W-1:0]          sq_next;

    always_comb
    begin
        diff = {rec[DIM_W-1], rec} - {qry[DIM_W-1], qry};
        mag  = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
        // The magnitude never exceeds 65535, so the top bit is always zero.
        sq_next = mag[DIM_W-1:0] * mag[DIM_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_reg <= sq_next;
        end
    end

endmodule

### sv/sqd_sum.sv
// Two-stage registered adder tree that merges the lane squares into one distance.
module sqd_sum
(
    input  logic                       clk,
    input  logic                       en,
    input  logic [sqd_pkg::SQ_W-1:0]   sq [sqd_pkg::NDIM],
    output logic [sqd_pkg::DIST_W-1:0] dist_reg
);
    import sqd_pkg::*;

    logic [GRP_W-1:0]  grp_next [NGRP];
    logic [GRP_W-1:0]  grp_reg  [NGRP];
    logic [DIST_W-1:0] dist_next;

    always_comb
    begin
        for (int g = 0; g < NGRP; g++)
        begin
            grp_next[g] = '0;
            for (int e = 0; e < GRP_SIZE; e++)
            begin
                if (g * GRP_SIZE + e < NDIM)
                begin
                    grp_next[g] = grp_next[g] + GRP_W'(sq[g * GRP_SIZE + e]);
                end
            end
        end
        dist_next = '0;
        for (int g = 0; g < NGRP; g++)
        begin
            dist_next = dist_next + DIST_W'(grp_reg[g]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            grp_reg  <= grp_next;
            dist_reg <= dist_next;
        end
    end

endmodule

### sv/sqd_topk.sv
// Top-K slot table with a pairwise ordering matrix that names the worst slot each cycle.
module sqd_topk
#(
    parameter int TOP_K = 5
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic [sqd_pkg::DIST_W-1:0] in_dist,
    input  sqd_pkg::meta_t             in_meta,
    output logic                       snap_valid,
    output sqd_pkg::slot_t             snap [TOP_K]
);
    import sqd_pkg::*;

    localparam int IDX_W = (TOP_K > 1) ? $clog2(TOP_K) : 1;

    slot_t            slot_reg    [TOP_K];
    slot_t            slot_next   [TOP_K];
    // better_reg[i][j] is set when slot i ranks strictly ahead of slot j.
    logic [TOP_K-1:0] better_reg  [TOP_K];
    logic [TOP_K-1:0] better_next [TOP_K];
    logic [TOP_K-1:0] new_lt;
    logic [TOP_K-1:0] slot_lt;
    logic [TOP_K-1:0] is_max;
    logic [IDX_W-1:0] worst;
    slot_t            cand;
    logic             ins;
    logic             matrix_ok;

    always_comb
    begin
        cand = '{distance: in_dist, label: in_meta.label, id: in_meta.id};
        for (int i = 0; i < TOP_K; i++)
        begin
            new_lt[i]  = pair_better(cand, slot_reg[i]);
            slot_lt[i] = pair_better(slot_reg[i], cand);
            is_max[i]  = ~|better_reg[i];
        end
        // The worst slot is the first one that no other slot ranks behind.
        worst = '0;
        for (int i = TOP_K - 1; i >= 0; i--)
        begin
            if (is_max[i])
            begin
                worst = IDX_W'(i);
            end
        end
        ins = in_valid && new_lt[worst];

        slot_next   = slot_reg;
        better_next = better_reg;
        if (ins)
        begin
            slot_next[worst] = cand;
            for (int j = 0; j < TOP_K; j++)
            begin
                better_next[worst][j] = (IDX_W'(j) != worst) && new_lt[j];
                better_next[j][worst] = (IDX_W'(j) != worst) && slot_lt[j];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TOP_K; i++)
            begin
                slot_reg[i]   <= SLOT_EMPTY;
                better_reg[i] <= '0;
            end
        end
        else if (in_valid && in_meta.last)
        begin
            for (int i = 0; i < TOP_K; i++)
            begin
                slot_reg[i]   <= SLOT_EMPTY;
                better_reg[i] <= '0;
            end
        end
        else
        begin
            slot_reg   <= slot_next;
            better_reg <= better_next;
        end
    end

    assign snap_valid = in_valid && in_meta.last;
    assign snap       = slot_next;

    always_comb
    begin
        matrix_ok = 1'b1;
        for (int i = 0; i < TOP_K; i++)
        begin
            for (int j = 0; j < TOP_K; j++)
            begin
                if (better_reg[i][j] != pair_better(slot_reg[i], slot_reg[j]))
                begin
                    matrix_ok = 1'b0;
                end
            end
        end
    end

`ifndef SYNTHESIS
    a_matrix_matches_slots: assert property (@(posedge clk) disable iff (!rst_n)
        matrix_ok)
        else $error("ordering matrix disagrees with slot contents");

    a_worst_exists: assert property (@(posedge clk) disable iff (!rst_n)
        is_max != '0)
        else $error("no slot qualifies as worst");

    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_meta.last) |=> (slot_reg[0] == SLOT_EMPTY && better_reg[0] == '0))
        else $error("table not cleared after last record");
`endif

endmodule

### sv/sqd_out.sv
// Result buffer that holds a snapshot of the slots and drains it one slot per transfer.
module sqd_out
#(
    parameter int TOP_K = 5
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       load,
    input  sqd_pkg::slot_t             slots [TOP_K],
    output logic                       free,
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    // Fields from bit 0: slot_distance[35:0], slot_label[43:36], slot_id[75:44], zero pad.
    output logic [sqd_pkg::OUT_W-1:0]  m_axis_tdata,
    // last_slot
    output logic                       m_axis_tlast
);
    import sqd_pkg::*;

    localparam int IDX_W = (TOP_K > 1) ? $clog2(TOP_K) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TOP_K - 1);

    slot_t            buf_reg [TOP_K];
    logic             busy_reg;
    logic [IDX_W-1:0] cnt_reg;
    logic             at_last;

    assign at_last = (cnt_reg == LAST_IDX);
    assign free    = !busy_reg || (m_axis_tready && at_last);

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            buf_reg <= slots;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (load)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg && m_axis_tready)
        begin
            if (at_last)
            begin
                busy_reg <= 1'b0;
                cnt_reg  <= '0;
            end
            else
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    assign m_axis_tvalid = busy_reg;
    assign m_axis_tdata  = {{PAD_W{1'b0}}, buf_reg[cnt_reg].id, buf_reg[cnt_reg].label,
                            buf_reg[cnt_reg].distance};
    assign m_axis_tlast  = at_last;

`ifndef SYNTHESIS
    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> free)
        else $error("snapshot loaded over an undelivered run");

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && !m_axis_tready) |=> (busy_reg && $stable(cnt_reg)))
        else $error("slot index moved while the receiver stalled");

    a_done_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && m_axis_tready && at_last && !load) |=> !busy_reg)
        else $error("buffer still busy after the final slot");
`endif

endmodule

### sv/squared_distance_top5_scan.sv
// Top level of the squared-distance top-K nearest-neighbor scan.
//
// Usage: write the 14-dimension query over the APB port (registers at byte
// addresses 0, 8, 16 and 24) while the block is idle. Records then stream in
// on the s_axis channel, one request per record, with tlast marking the final
// record of a scan. Each record runs through 14 parallel difference/square
// lanes, a two-stage adder tree and a five-slot compare-replace table.
// Throughput is one record per cycle while s_axis_tready is high. A record
// passes the lane, group-sum and distance registers before it updates the
// table; for a last record the TOP_K slots are then offered on m_axis in slot
// order, one request per cycle while m_axis_tready is high, with tlast on the
// final slot. The table is cleared in the same cycle that it is copied into
// the result buffer, so the next scan starts without a gap. The result buffer
// holds one run: when a second last record reaches the table before the
// previous run is drained, s_axis_tready drops until the buffer frees. A stall
// on m_axis holds the current slot and backs up into s_axis only in that way.
// Reset clears the query registers, empties the table (all-ones distance and
// id, zero label) and drops all valid flags.
module squared_distance_top5_scan
#(
    parameter int TOP_K = 5
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [sqd_pkg::ADDR_W-1:0]    paddr,
    input  logic [sqd_pkg::CFG_W-1:0]     pwdata,
    output logic [sqd_pkg::CFG_W-1:0]     prdata,
    output logic                          pready,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // Fields from bit 0: record_dims_0_3[63:0], record_dims_4_7[127:64],
    // record_dims_8_11[191:128], record_dims_12_13[223:192], record_label[231:224],
    // record_id[263:232].
    input  logic [sqd_pkg::IN_W-1:0]      s_axis_tdata,
    // last_record
    input  logic                          s_axis_tlast,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // Fields from bit 0: slot_distance[35:0], slot_label[43:36], slot_id[75:44], zero pad.
    output logic [sqd_pkg::OUT_W-1:0]     m_axis_tdata,
    // last_slot
    output logic                          m_axis_tlast
);
    import sqd_pkg::*;

    logic [CFG_W-1:0]  query0_reg;
    logic [CFG_W-1:0]  query1_reg;
    logic [CFG_W-1:0]  query2_reg;
    logic [Q3_W-1:0]   query3_reg;
    logic              cfg_wr;
    logic [1:0]        reg_idx;
    logic [QRY_W-1:0]  qry_flat;

    logic              en;
    logic              out_free;
    logic              v1_reg;
    logic              v2_reg;
    logic              v3_reg;
    meta_t             meta_in;
    meta_t             meta1_reg;
    meta_t             meta2_reg;
    meta_t             meta3_reg;
    logic [SQ_W-1:0]   sq [NDIM];
    logic [DIST_W-1:0] distance;
    logic              snap_valid;
    slot_t             snap [TOP_K];

    // Configuration port.
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign reg_idx = paddr[ADDR_W-1:3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            query0_reg <= '0;
            query1_reg <= '0;
            query2_reg <= '0;
            query3_reg <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (reg_idx)
                REG_Q0:  query0_reg <= pwdata;
                REG_Q1:  query1_reg <= pwdata;
                REG_Q2:  query2_reg <= pwdata;
                REG_Q3:  query3_reg <= pwdata[Q3_W-1:0];
                default: query0_reg <= query0_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_Q0:  prdata = query0_reg;
            REG_Q1:  prdata = query1_reg;
            REG_Q2:  prdata = query2_reg;
            REG_Q3:  prdata = CFG_W'(query3_reg);
            default: prdata = '0;
        endcase
    end

    assign qry_flat = {query3_reg, query2_reg, query1_reg, query0_reg};

    // The whole pipeline holds while a last record waits for the result buffer.
    assign en            = !(v3_reg && meta3_reg.last && !out_free);
    assign s_axis_tready = en;

    assign meta_in = '{last:  s_axis_tlast,
                       label: s_axis_tdata[NDIM*DIM_W +: LABEL_W],
                       id:    s_axis_tdata[NDIM*DIM_W + LABEL_W +: ID_W]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= s_axis_tvalid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            meta1_reg <= meta_in;
            meta2_reg <= meta1_reg;
            meta3_reg <= meta2_reg;
        end
    end

    for (genvar k = 0; k < NDIM; k++)
    begin : g_lane
        sqd_lane u_lane
        (
            .clk    (clk),
            .en     (en),
            .rec    (s_axis_tdata[k*DIM_W +: DIM_W]),
            .qry    (qry_flat[k*DIM_W +: DIM_W]),
            .sq_reg (sq[k])
        );
    end

    sqd_sum u_sum
    (
        .clk      (clk),
        .en       (en),
        .sq       (sq),
        .dist_reg (distance)
    );

    sqd_topk #(.TOP_K(TOP_K)) u_topk
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (v3_reg && en),
        .in_dist    (distance),
        .in_meta    (meta3_reg),
        .snap_valid (snap_valid),
        .snap       (snap)
    );

    sqd_out #(.TOP_K(TOP_K)) u_out
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (snap_valid),
        .slots         (snap),
        .free          (out_free),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule
